/* rtl/core/ttq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttq_pkg
// Types and constants shared by the touch tap qualifier core.
// ----------------------------------------------------------------------------
package ttq_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CMD_BITS     = 3;
    localparam int COUNT_BITS   = 4;
    localparam int ZONE_BITS    = 3;
    localparam int SLOP_BITS    = 8;
    localparam int TICK_BITS    = 8;
    localparam int IN_DATA_BITS = 32;
    localparam int OUT_DATA_BITS = 56;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SAMPLE   = 3'd0,
        CMD_CAP_PUSH = 3'd1,
        CMD_CAP_POP  = 3'd2,
        CMD_APP_TAKE = 3'd3,
        CMD_SYS_TAKE = 3'd4,
        CMD_TAP_DROP = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        REG_TAP_SLOP     = 2'd0,
        REG_HOLD_FINGERS = 2'd1,
        REG_ESCAPE_TICKS = 2'd2
    } t_reg_idx;

    localparam logic [ZONE_BITS-1:0] ZONE_NONE    = 3'd0;
    localparam logic [ZONE_BITS-1:0] ZONE_CLOSE   = 3'd1;
    localparam logic [ZONE_BITS-1:0] ZONE_BATTERY = 3'd4;

    localparam logic [SLOP_BITS-1:0]  TAP_SLOP_RST     = 8'd24;
    localparam logic [COUNT_BITS-1:0] HOLD_FINGERS_RST = 4'd4;
    localparam logic [TICK_BITS-1:0]  ESCAPE_TICKS_RST = 8'd40;
    localparam logic [TICK_BITS-1:0]  HOLD_MAX         = 8'd255;

    typedef struct packed {
        logic [SLOP_BITS-1:0]  tap_slop;
        logic [COUNT_BITS-1:0] hold_fingers;
        logic [TICK_BITS-1:0]  escape_ticks;
    } t_cfg;

    typedef struct packed {
        logic [ZONE_BITS-1:0]  bar_zone;
        logic                  fullscreen;
        logic [COORD_BITS-1:0] point_y;
        logic [COORD_BITS-1:0] point_x;
        logic [COUNT_BITS-1:0] finger_count;
    } t_item;

    typedef struct packed {
        logic                  is_captured;
        logic [COORD_BITS-1:0] tap_y;
        logic [COORD_BITS-1:0] tap_x;
        logic                  tap_valid;
        logic [COORD_BITS-1:0] touch_y;
        logic [COORD_BITS-1:0] touch_x;
        logic                  touch_down;
        logic                  escape;
        logic [ZONE_BITS-1:0]  bar_action;
        logic                  click;
    } t_result;

endpackage

/* rtl/core/ttq_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttq_cfg_regs
// APB register file for slop and escape hold settings.
// ----------------------------------------------------------------------------
module ttq_cfg_regs
    import ttq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_slop     <= TAP_SLOP_RST;
            r_cfg.hold_fingers <= HOLD_FINGERS_RST;
            r_cfg.escape_ticks <= ESCAPE_TICKS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TAP_SLOP:     r_cfg.tap_slop     <= pwdata[SLOP_BITS-1:0];
                REG_HOLD_FINGERS: r_cfg.hold_fingers <= pwdata[COUNT_BITS-1:0];
                REG_ESCAPE_TICKS: r_cfg.escape_ticks <= pwdata[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TAP_SLOP:     prdata = APB_DATA_BITS'(r_cfg.tap_slop);
            REG_HOLD_FINGERS: prdata = APB_DATA_BITS'(r_cfg.hold_fingers);
            REG_ESCAPE_TICKS: prdata = APB_DATA_BITS'(r_cfg.escape_ticks);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/ttq_logic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttq_logic
// Tap qualification state and per-word result logic.
// ----------------------------------------------------------------------------
module ttq_logic
    import ttq_pkg::*;
#(
    parameter int MAX_CAPTURE_DEPTH = 15
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_cmd    i_cmd,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int DEPTH_BITS = (MAX_CAPTURE_DEPTH < 2) ? 1 : $clog2(MAX_CAPTURE_DEPTH + 1);
    localparam logic [DEPTH_BITS-1:0] MaxDepth = DEPTH_BITS'(MAX_CAPTURE_DEPTH);

    logic                  r_was_down,  n_was_down;
    logic [COORD_BITS-1:0] r_last_x,    n_last_x;
    logic [COORD_BITS-1:0] r_last_y,    n_last_y;
    logic [ZONE_BITS-1:0]  r_last_zone, n_last_zone;
    logic [COORD_BITS-1:0] r_press_x,   n_press_x;
    logic [COORD_BITS-1:0] r_press_y,   n_press_y;
    logic                  r_tap_pend,  n_tap_pend;
    logic [COORD_BITS-1:0] r_pend_x,    n_pend_x;
    logic [COORD_BITS-1:0] r_pend_y,    n_pend_y;
    logic [DEPTH_BITS-1:0] r_depth,     n_depth;
    logic [TICK_BITS-1:0]  r_hold,      n_hold;

    logic                  down;
    logic                  hold_arm;
    logic [TICK_BITS-1:0]  hold_inc;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] slop;
    logic                  in_slop;
    logic                  bar_zone_hit;
    logic                  take;
    t_result               res;

    assign down     = (i_item.finger_count != '0);
    assign hold_arm = (i_item.finger_count >= i_cfg.hold_fingers) & i_item.fullscreen;
    assign hold_inc = (r_hold < HOLD_MAX) ? r_hold + 1'b1 : r_hold;
    assign dx       = (r_last_x >= r_press_x) ? r_last_x - r_press_x : r_press_x - r_last_x;
    assign dy       = (r_last_y >= r_press_y) ? r_last_y - r_press_y : r_press_y - r_last_y;
    assign slop     = COORD_BITS'(i_cfg.tap_slop);
    assign in_slop  = (dx <= slop) & (dy <= slop);
    assign bar_zone_hit = (r_last_zone >= ZONE_CLOSE) & (r_last_zone <= ZONE_BATTERY);

    always_comb begin
        n_was_down  = r_was_down;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_last_zone = r_last_zone;
        n_press_x   = r_press_x;
        n_press_y   = r_press_y;
        n_tap_pend  = r_tap_pend;
        n_pend_x    = r_pend_x;
        n_pend_y    = r_pend_y;
        n_depth     = r_depth;
        n_hold      = r_hold;
        take        = 1'b0;
        res         = '0;

        case (i_cmd)
            CMD_SAMPLE: begin
                if (!hold_arm) begin
                    n_hold = '0;
                end else if (hold_inc >= i_cfg.escape_ticks) begin
                    n_hold     = '0;
                    res.escape = 1'b1;
                end else begin
                    n_hold = hold_inc;
                end
                if (down) begin
                    n_last_x    = i_item.point_x;
                    n_last_y    = i_item.point_y;
                    n_last_zone = (i_item.bar_zone <= ZONE_BATTERY) ? i_item.bar_zone : ZONE_NONE;
                    if (!r_was_down) begin
                        n_press_x = i_item.point_x;
                        n_press_y = i_item.point_y;
                        res.click = 1'b1;
                    end
                end else if (r_was_down && in_slop) begin
                    if ((r_depth == '0) && bar_zone_hit) begin
                        res.bar_action = r_last_zone;
                    end else begin
                        n_pend_x   = r_last_x;
                        n_pend_y   = r_last_y;
                        n_tap_pend = 1'b1;
                    end
                end
                n_was_down = down;
            end
            CMD_CAP_PUSH: begin
                if (r_depth < MaxDepth) n_depth = r_depth + 1'b1;
                n_tap_pend = 1'b0;
            end
            CMD_CAP_POP: begin
                if (r_depth != '0) n_depth = r_depth - 1'b1;
                n_tap_pend = 1'b0;
            end
            CMD_APP_TAKE: take = (r_depth == '0);
            CMD_SYS_TAKE: take = 1'b1;
            CMD_TAP_DROP: n_tap_pend = 1'b0;
            default: ;
        endcase

        if (take && r_tap_pend) begin
            res.tap_valid = 1'b1;
            res.tap_x     = r_pend_x;
            res.tap_y     = r_pend_y;
            n_tap_pend    = 1'b0;
        end

        if (n_depth == '0) begin
            res.touch_down = n_was_down;
            res.touch_x    = n_last_x;
            res.touch_y    = n_last_y;
        end
        res.is_captured = (n_depth != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_down  <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_last_zone <= ZONE_NONE;
            r_press_x   <= '0;
            r_press_y   <= '0;
            r_tap_pend  <= 1'b0;
            r_pend_x    <= '0;
            r_pend_y    <= '0;
            r_depth     <= '0;
            r_hold      <= '0;
        end else if (i_en) begin
            r_was_down  <= n_was_down;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_last_zone <= n_last_zone;
            r_press_x   <= n_press_x;
            r_press_y   <= n_press_y;
            r_tap_pend  <= n_tap_pend;
            r_pend_x    <= n_pend_x;
            r_pend_y    <= n_pend_y;
            r_depth     <= n_depth;
            r_hold      <= n_hold;
        end
    end

    assign o_res = res;

endmodule

/* rtl/core/touch_tap_qualifier_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_qualifier_core
// Touch tap qualifier: press click, slop-qualified taps, bar actions,
// capture nesting and a multi-finger escape hold.
// Throughput: one word per cycle while the result stream is not stalled; the
//   state update sits between the input register and the result register.
// Reset: synchronous, active low; clears all tracking state and restores
//   register defaults (slop 24, escape fingers 4, escape ticks 40).
// ----------------------------------------------------------------------------
module touch_tap_qualifier_core
    import ttq_pkg::*;
#(
    parameter int MAX_CAPTURE_DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // finger_count, point_x, point_y, fullscreen, bar_zone
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // cmd
    input  logic [CMD_BITS-1:0]      i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // click, bar_action, escape, touch_down, touch_x, touch_y, tap_valid,
    // tap_x, tap_y, is_captured
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_cfg                    cfg;
    logic                    r_in_vld;
    logic [IN_DATA_BITS-1:0] r_in_data;
    logic [CMD_BITS-1:0]     r_in_cmd;
    logic                    r_out_vld;
    t_result                 r_out;
    t_result                 res;
    t_item                   item;
    logic                    advance;

    ttq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance    = r_in_vld & (~r_out_vld | i_m_tready);
    assign o_s_tready = ~r_in_vld | advance;
    assign item       = t_item'(r_in_data[$bits(t_item)-1:0]);

    ttq_logic #(
        .MAX_CAPTURE_DEPTH (MAX_CAPTURE_DEPTH)
    ) u_logic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_cmd   (t_cmd'(r_in_cmd)),
        .i_item  (item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_data <= i_s_tdata;
            r_in_cmd  <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_DATA_BITS'(r_out);

    a_captured_hides_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.is_captured) |->
            (!r_out.touch_down && r_out.touch_x == '0 && r_out.touch_y == '0
             && r_out.bar_action == ZONE_NONE))
        else $error("captured result exposes touch or bar action");

    a_click_is_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.click) |-> (r_out.touch_down || r_out.is_captured))
        else $error("click without finger down");

    a_take_excludes_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.tap_valid) |->
            (!r_out.click && !r_out.escape && r_out.bar_action == ZONE_NONE))
        else $error("tap take result carries sample events");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result changed");

endmodule

/* dv/touch_tap_qualifier_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_tap_qualifier_core_test
// Self-checking bench for the touch tap qualifier core. Drives poll samples
// and commands on the input stream and computes the expected result word for
// each one with a local model of the tap, capture and escape logic. Every
// output word is compared field by field. A directed table runs first,
// then random gestures, escape holds, capture bursts and noise under several
// register settings, with random idling on both streams during the first 740 words.
// ----------------------------------------------------------------------------
module touch_tap_qualifier_core_test;
    import ttq_pkg::*;

    localparam int MAX_NEST = 15;
    localparam logic [ZONE_BITS-1:0] ZONE_WIFI  = 3'd2;
    localparam logic [ZONE_BITS-1:0] ZONE_CLOCK = 3'd3;
    localparam logic [CMD_BITS-1:0]  CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_BITS-1:0]  CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [CMD_BITS-1:0] cmd;
        t_item               itm;
        bit                  typed;
        t_result             want;
    } t_dir_row;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [IN_DATA_BITS-1:0]  i_s_tdata = '0;
    logic [CMD_BITS-1:0]      i_s_tuser = '0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // model state
    logic [SLOP_BITS-1:0]  slop_cfg    = TAP_SLOP_RST;
    logic [COUNT_BITS-1:0] fingers_cfg = HOLD_FINGERS_RST;
    logic [TICK_BITS-1:0]  ticks_cfg   = ESCAPE_TICKS_RST;
    logic                  pen_down    = 1'b0;
    logic [COORD_BITS-1:0] cur_x = '0, cur_y = '0;
    logic [ZONE_BITS-1:0]  cur_zone = ZONE_NONE;
    logic [COORD_BITS-1:0] anchor_x = '0, anchor_y = '0;
    logic                  tap_held = 1'b0;
    logic [COORD_BITS-1:0] held_x = '0, held_y = '0;
    int unsigned           nest_depth = 0;
    logic [TICK_BITS-1:0]  hold_ticks = '0;

    t_result     expected_results[$];
    t_dir_row    dir_rows[$];
    int          mismatch_count = 0;
    int unsigned words_sent = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;

    touch_tap_qualifier_core #(
        .MAX_CAPTURE_DEPTH(MAX_NEST)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_item mk_item(input int unsigned n, input logic [COORD_BITS-1:0] x,
                                      input logic [COORD_BITS-1:0] y, input logic full,
                                      input logic [ZONE_BITS-1:0] zone);
        t_item itm;
        itm.finger_count = n[COUNT_BITS-1:0];
        itm.point_x      = x;
        itm.point_y      = y;
        itm.fullscreen   = full;
        itm.bar_zone     = zone;
        return itm;
    endfunction

    function automatic t_result predict_result(input logic [CMD_BITS-1:0] cmd, input t_item itm);
        t_result               res;
        logic                  down;
        logic                  taking;
        logic [COORD_BITS-1:0] dx, dy;
        res = '0;
        taking = 1'b0;
        case (cmd)
            CMD_SAMPLE: begin
                down = (itm.finger_count != 0);
                if (itm.finger_count < fingers_cfg || !itm.fullscreen) begin
                    hold_ticks = '0;
                end else begin
                    if (hold_ticks != HOLD_MAX) hold_ticks = hold_ticks + 1'b1;
                    if (hold_ticks >= ticks_cfg) begin
                        hold_ticks = '0;
                        res.escape = 1'b1;
                    end
                end
                if (down) begin
                    cur_x = itm.point_x;
                    cur_y = itm.point_y;
                    cur_zone = (itm.bar_zone <= ZONE_BATTERY) ? itm.bar_zone : ZONE_NONE;
                    if (!pen_down) begin
                        anchor_x = itm.point_x;
                        anchor_y = itm.point_y;
                        res.click = 1'b1;
                    end
                end else if (pen_down) begin
                    dx = (cur_x >= anchor_x) ? cur_x - anchor_x : anchor_x - cur_x;
                    dy = (cur_y >= anchor_y) ? cur_y - anchor_y : anchor_y - cur_y;
                    if (dx <= slop_cfg && dy <= slop_cfg) begin
                        if (nest_depth == 0 && cur_zone != ZONE_NONE) begin
                            res.bar_action = cur_zone;
                        end else begin
                            held_x = cur_x;
                            held_y = cur_y;
                            tap_held = 1'b1;
                        end
                    end
                end
                pen_down = down;
            end
            CMD_CAP_PUSH: begin
                if (nest_depth < MAX_NEST) nest_depth++;
                tap_held = 1'b0;
            end
            CMD_CAP_POP: begin
                if (nest_depth > 0) nest_depth--;
                tap_held = 1'b0;
            end
            CMD_APP_TAKE: taking = (nest_depth == 0);
            CMD_SYS_TAKE: taking = 1'b1;
            CMD_TAP_DROP: tap_held = 1'b0;
            default: ;
        endcase
        if (taking && tap_held) begin
            res.tap_valid = 1'b1;
            res.tap_x = held_x;
            res.tap_y = held_y;
            tap_held = 1'b0;
        end
        if (nest_depth == 0) begin
            res.touch_down = pen_down;
            res.touch_x = cur_x;
            res.touch_y = cur_y;
        end
        res.is_captured = (nest_depth > 0);
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata);
            if (expected_results.size() == 0) begin
                $error("result word with no expectation pending");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("click",       want.click,       got.click);
                check_field("bar_action",  want.bar_action,  got.bar_action);
                check_field("escape",      want.escape,      got.escape);
                check_field("touch_down",  want.touch_down,  got.touch_down);
                check_field("touch_x",     want.touch_x,     got.touch_x);
                check_field("touch_y",     want.touch_y,     got.touch_y);
                check_field("tap_valid",   want.tap_valid,   got.tap_valid);
                check_field("tap_x",       want.tap_x,       got.tap_x);
                check_field("tap_y",       want.tap_y,       got.tap_y);
                check_field("is_captured", want.is_captured, got.is_captured);
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(input logic [CMD_BITS-1:0] cmd, input t_item itm,
                             input bit typed = 1'b0, input t_result want = '0);
        t_result res;
        if (words_sent < 370) begin
            send_gap_pct = 26;
            recv_stall_pct = 53;
        end else if (words_sent < 740) begin
            send_gap_pct = 53;
            recv_stall_pct = 26;
        end else begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= itm;
        i_s_tuser <= cmd;
        res = predict_result(cmd, itm);
        expected_results.push_back(typed ? want : res);
        words_sent++;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // hold off until every pending result word is back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TAP_SLOP:     slop_cfg = val[SLOP_BITS-1:0];
            REG_HOLD_FINGERS: fingers_cfg = val[COUNT_BITS-1:0];
            REG_ESCAPE_TICKS: ticks_cfg = val[TICK_BITS-1:0];
            default: ;
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", val, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] c);
        int span, v;
        span = int'(slop_cfg) + 2;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic tap_gesture();
        int unsigned           fingers;
        logic [COORD_BITS-1:0] ax, ay;
        logic [ZONE_BITS-1:0]  zone;
        fingers = ($urandom_range(3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 2);
        ax = COORD_BITS'($urandom);
        ay = COORD_BITS'($urandom);
        zone = ZONE_BITS'($urandom_range(7));
        send_word(CMD_SAMPLE, mk_item(fingers, ax, ay, 1'($urandom_range(1)), zone));
        repeat ($urandom_range(0, 3)) begin
            send_word(CMD_SAMPLE, mk_item(fingers, nudge(ax), nudge(ay), 1'($urandom_range(1)),
                                          ($urandom_range(3) == 0) ?
                                              ZONE_BITS'($urandom_range(7)) : zone));
        end
        send_word(CMD_SAMPLE, mk_item(0, COORD_BITS'($urandom), COORD_BITS'($urandom),
                                      1'($urandom_range(1)), ZONE_BITS'($urandom_range(7))));
        if ($urandom_range(1)) begin
            send_word($urandom_range(1) ? CMD_APP_TAKE : CMD_SYS_TAKE, t_item'($urandom));
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned           target, pick, fingers, len;
        logic [COORD_BITS-1:0] hx, hy;
        target = words_sent + count;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                tap_gesture();
            end else if (pick < 55) begin
                fingers = $urandom_range(fingers_cfg, 15);
                len = $urandom_range(1) ? int'(ticks_cfg) + $urandom_range(0, 2)
                                        : $urandom_range(1, int'(ticks_cfg) + 1);
                hx = COORD_BITS'($urandom);
                hy = COORD_BITS'($urandom);
                repeat (len) begin
                    send_word(CMD_SAMPLE, mk_item(fingers, nudge(hx), nudge(hy),
                                                  ($urandom_range(19) != 0),
                                                  ZONE_BITS'($urandom_range(7))));
                end
                send_word(CMD_SAMPLE, mk_item(0, COORD_BITS'($urandom), COORD_BITS'($urandom),
                                              1'b1, ZONE_NONE));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 3)) begin
                    send_word(CMD_BITS'($urandom_range(1, 7)), t_item'($urandom));
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(MAX_NEST - 1, MAX_NEST + 2)) begin
                    send_word(CMD_CAP_PUSH, t_item'($urandom));
                end
                tap_gesture();
                repeat ($urandom_range(MAX_NEST - 2, MAX_NEST + 2)) begin
                    send_word(CMD_CAP_POP, t_item'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(CMD_BITS'($urandom_range(7)), t_item'($urandom));
                end
            end
        end
    endtask

    initial begin
        t_item       blank;
        int unsigned slop_set[5]    = '{24, 0, 255, 8, 40};
        int unsigned fingers_set[5] = '{4, 1, 10, 2, 3};
        int unsigned ticks_set[5]   = '{40, 0, 255, 1, 5};
        int unsigned quota[5]       = '{230, 200, 250, 170, 150};

        blank = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows.push_back('{CMD_APP_TAKE, blank, 1'b1, t_result'('0)});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(1, 12'd4095, 12'd4095, 1'b0, ZONE_NONE), 1'b1,
                             t_result'{click: 1'b1, touch_down: 1'b1, touch_x: 12'd4095,
                                       touch_y: 12'd4095, default: '0}});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(0, 12'd0, 12'd0, 1'b1, ZONE_BATTERY), 1'b1,
                             t_result'{touch_x: 12'd4095, touch_y: 12'd4095, default: '0}});
        dir_rows.push_back('{CMD_SYS_TAKE, blank, 1'b1,
                             t_result'{tap_valid: 1'b1, tap_x: 12'd4095, tap_y: 12'd4095,
                                       touch_x: 12'd4095, touch_y: 12'd4095, default: '0}});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(15, 12'd0, 12'd0, 1'b1, 3'd7), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_TAP_DROP, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_APP_TAKE, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(2, 12'd100, 12'd200, 1'b0, ZONE_WIFI), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(2, 12'd124, 12'd176, 1'b0, ZONE_WIFI), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(1, 12'd100, 12'd200, 1'b0, ZONE_CLOCK), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(1, 12'd125, 12'd200, 1'b0, ZONE_CLOCK), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_CAP_PUSH, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(1, 12'd50, 12'd60, 1'b0, ZONE_CLOSE), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_APP_TAKE, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_SYS_TAKE, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_CAP_POP, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_CAP_POP, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_SPARE_6, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_SPARE_7, blank, 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, mk_item(4, 12'd10, 12'd10, 1'b1, ZONE_BATTERY), 1'b0, '0});
        dir_rows.push_back('{CMD_SAMPLE, blank, 1'b0, '0});

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].cmd, dir_rows[i].itm, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < 5; p++) begin
            if (p != 0) begin
                drain();
                repeat (4) @(posedge i_clk);
                write_reg(REG_TAP_SLOP, slop_set[p]);
                write_reg(REG_HOLD_FINGERS, fingers_set[p]);
                write_reg(REG_ESCAPE_TICKS, ticks_set[p]);
            end
            run_random(quota[p] / 2);
            drain();
            run_random(quota[p] - quota[p] / 2);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
